FILE: rtl/core/png_metadata_chunk_filter_unit_assert.svh
// Assertion macros shared by the checker of png_metadata_chunk_filter_unit.
// Each macro expands to one labeled concurrent assertion clocked on clk_i,
// disabled while rst_ni is low.
`ifndef PNG_METADATA_CHUNK_FILTER_UNIT_ASSERT_SVH
`define PNG_METADATA_CHUNK_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PMCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pmcf_pkg.sv
// Package for the PNG metadata chunk filter: job type, codes and constants.
// Used by every module of the block and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package pmcf_pkg;

  // Output field layout of m_axis_tdata, lowest bit first.
  localparam int unsigned OUT_TDATA_W = 112;
  localparam int unsigned CNT_OUT_W   = 40;
  localparam int unsigned CHUNK_CNT_W = 16;

  localparam int unsigned OB_BYTE_LSB   = 0;
  localparam int unsigned OB_FIN_BIT    = 8;
  localparam int unsigned OB_STATUS_LSB = 9;
  localparam int unsigned OB_RCHK_LSB   = 11;
  localparam int unsigned OB_RBYT_LSB   = 27;
  localparam int unsigned OB_KEPT_LSB   = 67;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);

  // Final status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIG   = 2'd1;
  localparam logic [1:0] ST_TRUNC_HDR = 2'd2;
  localparam logic [1:0] ST_SHORT_CHK = 2'd3;

  // Signature, first byte in the top bits.
  localparam logic [63:0] PNG_SIG = 64'h8950_4E47_0D0A_1A0A;

  localparam logic [31:0] TAG_IEND = 32'h4945_4E44;
  localparam logic [31:0] TAG_TEXT = 32'h7445_5874;
  localparam logic [31:0] TAG_ZTXT = 32'h7A54_5874;
  localparam logic [31:0] TAG_ITXT = 32'h6954_5874;
  localparam logic [31:0] TAG_TIME = 32'h7449_4D45;
  localparam logic [31:0] TAG_EXIF = 32'h6558_4966;
  localparam logic [31:0] TAG_CABX = 32'h6361_4258;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_BURST = 2'd2
  } pmcf_kind_e;

  // One job per accepted input transaction.
  typedef struct packed {
    pmcf_kind_e              kind;
    logic [63:0]             data;       // burst bytes, first in top bits; single byte in [7:0]
    logic                    finished;
    logic [1:0]              status;
    logic [CHUNK_CNT_W-1:0]  removed_chunks;
    logic [CNT_OUT_W-1:0]    removed_bytes;
    logic [CNT_OUT_W-1:0]    kept_bytes;
  } pmcf_job_t;

  function automatic logic is_drop_tag(logic [31:0] tag);
    return (tag == TAG_TEXT) || (tag == TAG_ZTXT) || (tag == TAG_ITXT) ||
           (tag == TAG_TIME) || (tag == TAG_EXIF) || (tag == TAG_CABX);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pmcf_front.sv
// Front end: parses signature and chunk headers, tracks chunk state and
// counters, and issues one job per input transaction. Depends on pmcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmcf_front #(
  parameter int unsigned COUNT_WIDTH = 40
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 item_valid_i,
  input  wire                 cmd_i,
  input  wire  [7:0]          byte_i,
  output logic                item_ready_o,
  input  wire                 job_ready_i,
  output logic                job_valid_o,
  output pmcf_pkg::pmcf_job_t job_o
);
  import pmcf_pkg::*;

  localparam int unsigned SUM_W = COUNT_WIDTH + 2;

  typedef enum logic [4:0] {
    PH_SIG  = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_KEEP = 5'b00100,
    PH_DROP = 5'b01000,
    PH_DONE = 5'b10000
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [63:0]            hdr_q, hdr_d;
  logic [2:0]             hcnt_q, hcnt_d;
  logic [32:0]            rem_q, rem_d;
  logic                   is_end_q, is_end_d;
  logic [1:0]             status_q, status_d;
  logic [CHUNK_CNT_W-1:0] chk_cnt_q, chk_cnt_d;
  logic [COUNT_WIDTH-1:0] drop_cnt_q, drop_cnt_d;
  logic [COUNT_WIDTH-1:0] kept_cnt_q, kept_cnt_d;

  logic                   accept;
  logic [63:0]            hdr_shift;
  logic [31:0]            chunk_len;
  logic [32:0]            rem_dec;
  logic [SUM_W-1:0]       drop_sum;
  logic [SUM_W-1:0]       kept_sum;
  logic [3:0]             kept_add;
  logic                   fin;
  pmcf_kind_e             kind;
  logic [63:0]            job_data;
  logic [CNT_OUT_W+COUNT_WIDTH-1:0] drop_ext;
  logic [CNT_OUT_W+COUNT_WIDTH-1:0] kept_ext;

  assign accept       = item_valid_i && job_ready_i;
  assign item_ready_o = job_ready_i;

  assign hdr_shift = {hdr_q[55:0], byte_i};
  assign chunk_len = hdr_shift[63:32];
  assign rem_dec   = (rem_q != 33'd0) ? rem_q - 33'd1 : rem_q;
  // Whole dropped chunk is counted once its header is in: length + 12.
  assign drop_sum  = SUM_W'(drop_cnt_q) + SUM_W'(chunk_len) + SUM_W'(12);
  assign kept_sum  = SUM_W'(kept_cnt_q) + SUM_W'(kept_add);

  always_comb begin
    phase_d    = phase_q;
    hdr_d      = hdr_q;
    hcnt_d     = hcnt_q;
    rem_d      = rem_q;
    is_end_d   = is_end_q;
    status_d   = status_q;
    chk_cnt_d  = chk_cnt_q;
    drop_cnt_d = drop_cnt_q;
    kept_add   = 4'd0;
    fin        = 1'b0;
    kind       = KIND_NONE;
    job_data   = 64'd0;

    case (phase_q)
      PH_SIG: begin
        if (cmd_i || (byte_i != PNG_SIG[{~hcnt_q, 3'b000} +: 8])) begin
          fin      = 1'b1;
          status_d = ST_BAD_SIG;
        end else if (hcnt_q == 3'd7) begin
          kind     = KIND_BURST;
          job_data = PNG_SIG;
          kept_add = 4'd8;
          hcnt_d   = 3'd0;
          hdr_d    = 64'd0;
          phase_d  = PH_HDR;
        end else begin
          hcnt_d = hcnt_q + 3'd1;
        end
      end
      PH_HDR: begin
        if (cmd_i) begin
          fin      = 1'b1;
          status_d = hcnt_q[2] ? ST_TRUNC_HDR : ST_OK;
        end else begin
          hdr_d = hdr_shift;
          if (hcnt_q == 3'd7) begin
            hcnt_d   = 3'd0;
            rem_d    = {1'b0, chunk_len} + 33'd4;
            is_end_d = (hdr_shift[31:0] == TAG_IEND);
            if (is_drop_tag(hdr_shift[31:0])) begin
              if (chk_cnt_q != {CHUNK_CNT_W{1'b1}}) begin
                chk_cnt_d = chk_cnt_q + 1'b1;
              end
              drop_cnt_d = (drop_sum[SUM_W-1:COUNT_WIDTH] != '0) ?
                           {COUNT_WIDTH{1'b1}} : drop_sum[COUNT_WIDTH-1:0];
              phase_d    = PH_DROP;
            end else begin
              kind     = KIND_BURST;
              job_data = hdr_shift;
              kept_add = 4'd8;
              phase_d  = PH_KEEP;
            end
          end else begin
            hcnt_d = hcnt_q + 3'd1;
          end
        end
      end
      PH_KEEP, PH_DROP: begin
        if (cmd_i) begin
          fin      = 1'b1;
          status_d = (phase_q == PH_KEEP) ? ST_SHORT_CHK : ST_OK;
        end else begin
          if (phase_q == PH_KEEP) begin
            kind          = KIND_BYTE;
            job_data[7:0] = byte_i;
            kept_add      = 4'd1;
          end
          rem_d = rem_dec;
          if (rem_dec == 33'd0) begin
            if (is_end_q) begin
              fin      = 1'b1;
              status_d = ST_OK;
            end else begin
              phase_d = PH_HDR;
            end
          end
        end
      end
      default: ;
    endcase

    if (fin) begin
      phase_d = PH_DONE;
    end
  end

  assign kept_cnt_d = (kept_sum[SUM_W-1:COUNT_WIDTH] != '0) ?
                      {COUNT_WIDTH{1'b1}} : kept_sum[COUNT_WIDTH-1:0];

  assign drop_ext = {{CNT_OUT_W{1'b0}}, drop_cnt_d};
  assign kept_ext = {{CNT_OUT_W{1'b0}}, kept_cnt_d};

  always_comb begin
    job_o.kind           = kind;
    job_o.data           = job_data;
    job_o.finished       = (phase_d == PH_DONE);
    job_o.status         = (phase_d == PH_DONE) ? status_d : ST_OK;
    job_o.removed_chunks = chk_cnt_d;
    job_o.removed_bytes  = drop_ext[CNT_OUT_W-1:0];
    job_o.kept_bytes     = kept_ext[CNT_OUT_W-1:0];
  end

  assign job_valid_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIG;
      hdr_q      <= 64'd0;
      hcnt_q     <= 3'd0;
      rem_q      <= 33'd0;
      is_end_q   <= 1'b0;
      status_q   <= ST_OK;
      chk_cnt_q  <= '0;
      drop_cnt_q <= '0;
      kept_cnt_q <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      hdr_q      <= hdr_d;
      hcnt_q     <= hcnt_d;
      rem_q      <= rem_d;
      is_end_q   <= is_end_d;
      status_q   <= status_d;
      chk_cnt_q  <= chk_cnt_d;
      drop_cnt_q <= drop_cnt_d;
      kept_cnt_q <= kept_cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pmcf_queue.sv
// Short job queue between front end and back end.
// Depends on pmcf_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module pmcf_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  pmcf_pkg::pmcf_job_t wr_job_i,
  input  wire                 pop_i,
  output pmcf_pkg::pmcf_job_t head_o,
  output logic                empty_o,
  output logic                full_o
);
  import pmcf_pkg::*;

  pmcf_job_t         mem_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QIDX_W:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QIDX_W+1)'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pmcf_back.sv
// Back end: expands each job into one or eight results and holds them in
// the output register. Depends on pmcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmcf_back (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  pmcf_pkg::pmcf_job_t                head_i,
  input  wire                                head_valid_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [pmcf_pkg::OUT_TDATA_W-1:0]   out_data_o,
  output logic                               out_user_o,
  output logic                               out_last_o
);
  import pmcf_pkg::*;

  logic [2:0]             idx_q, idx_d;
  logic                   valid_q;
  logic [OUT_TDATA_W-1:0] data_q;
  logic                   user_q;
  logic                   last_q;

  logic                   load;
  logic                   last;
  logic [7:0]             res_byte;
  logic [2:0]             sel;
  logic [OUT_TDATA_W-1:0] res_data;

  assign load = head_valid_i && (!valid_q || out_ready_i);
  assign last = (head_i.kind != KIND_BURST) || (idx_q == 3'd7);
  assign sel  = ~idx_q;   // first burst byte sits in the top bits

  always_comb begin
    case (head_i.kind)
      KIND_BURST: res_byte = head_i.data[{sel, 3'b000} +: 8];
      KIND_BYTE:  res_byte = head_i.data[7:0];
      default:    res_byte = 8'd0;
    endcase
  end

  assign res_data = {5'd0, head_i.kept_bytes, head_i.removed_bytes,
                     head_i.removed_chunks, head_i.status, head_i.finished, res_byte};

  assign pop_o = load && last;
  assign idx_d = load ? (last ? 3'd0 : idx_q + 3'd1) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_data;
      user_q <= (head_i.kind != KIND_NONE);
      last_q <= last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

FILE: rtl/core/png_metadata_chunk_filter_unit.sv
// Top level of the PNG metadata chunk filter: front end, job queue, back end.
// Depends on pmcf_pkg, pmcf_front, pmcf_queue and pmcf_back.
//
// Usage: s_axis carries one file byte per transaction (tdata) with tuser low;
// a transaction with tuser high marks end of stream. m_axis returns, per input
// transaction, either one result with no byte (tuser low) or one or eight
// byte results (tuser high); tlast marks the last result of that input.
// The 8 signature bytes and the 8 header bytes of each kept chunk leave as a
// burst of eight results; every other kept byte gives one result.
// Each result also carries finished, status and the saturating counters as
// they stand after the input that caused it.
// The first result of an input passes through the job queue and then the
// output register before it shows on m_axis. Input is taken every cycle
// while the 4-entry job queue has room; output runs at one result per cycle
// while the receiver is ready, so a header burst of eight results holds the
// output and the queue fills behind it.
// Reset puts the parser at the signature and clears all counters. When the
// receiver stalls, the output register holds its result, the queue fills and
// s_axis_tready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none

module png_metadata_chunk_filter_unit #(
  parameter int unsigned COUNT_WIDTH = 40
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [7:0]                         s_axis_tdata,   // in_byte
  input  wire                                s_axis_tuser,   // cmd
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // out_byte[7:0], finished[8], status[10:9], removed_chunks[26:11],
  // removed_bytes[66:27], kept_bytes[106:67], zero[111:107]
  output logic [pmcf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tuser,   // byte_valid
  output logic                               m_axis_tlast    // run_last
);
  import pmcf_pkg::*;

  pmcf_job_t job;
  pmcf_job_t head;
  logic      job_valid;
  logic      q_full;
  logic      q_empty;
  logic      pop;

  pmcf_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .cmd_i        (s_axis_tuser),
    .byte_i       (s_axis_tdata),
    .item_ready_o (s_axis_tready),
    .job_ready_i  (!q_full),
    .job_valid_o  (job_valid),
    .job_o        (job)
  );

  pmcf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (job_valid),
    .wr_job_i (job),
    .pop_i    (pop),
    .head_o   (head),
    .empty_o  (q_empty),
    .full_o   (q_full)
  );

  pmcf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/core/pmcf_checker.sv
// Port-level checks on the output stream of png_metadata_chunk_filter_unit,
// bound to the top level. Depends on pmcf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "png_metadata_chunk_filter_unit_assert.svh"

module pmcf_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [pmcf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire                              m_axis_tuser,
  input wire                              m_axis_tlast
);
  import pmcf_pkg::*;

  logic                 out_acc;
  logic                 fin;
  logic [1:0]           status;
  logic [CNT_OUT_W-1:0] kept;
  logic                 seen_fin_q;
  logic [1:0]           fin_status_q;
  logic                 seen_any_q;
  logic [CNT_OUT_W-1:0] kept_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign fin     = m_axis_tdata[OB_FIN_BIT];
  assign status  = m_axis_tdata[OB_STATUS_LSB +: 2];
  assign kept    = m_axis_tdata[OB_KEPT_LSB +: CNT_OUT_W];

  // Track what earlier output transactions showed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_fin_q   <= 1'b0;
      fin_status_q <= ST_OK;
      seen_any_q   <= 1'b0;
      kept_q       <= '0;
    end else if (out_acc) begin
      seen_any_q <= 1'b1;
      kept_q     <= kept;
      if (fin && !seen_fin_q) begin
        seen_fin_q   <= 1'b1;
        fin_status_q <= status;
      end
    end
  end

  `PMCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
  `PMCF_ASSERT_NOW(a_fin_sticky, out_acc && seen_fin_q, fin && (status == fin_status_q), "finish state not kept")
  `PMCF_ASSERT_NOW(a_nobyte_alone, out_acc && !m_axis_tuser, m_axis_tlast && (m_axis_tdata[7:0] == 8'd0), "empty result not alone")
  `PMCF_ASSERT_NOW(a_status_fin, m_axis_tvalid && !fin, status == ST_OK, "status set before finish")
  `PMCF_ASSERT_NOW(a_kept_mono, out_acc && seen_any_q, kept >= kept_q, "kept byte count went down")

endmodule

bind png_metadata_chunk_filter_unit pmcf_checker u_pmcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
